[design/kpc_pkg.sv]
// ----------------------------------------------------------------------------
// kpc_pkg
// Types and constants for the key press classifier: phases, event codes,
// register map and reset values.
// ----------------------------------------------------------------------------
package kpc_pkg;

   localparam int unsigned TimeWidthDefault = 16;
   localparam int unsigned CfgWidth         = 16;
   localparam int unsigned CsrAddrWidth     = 4;
   localparam int unsigned CsrDataWidth     = 32;
   localparam int unsigned ReqDataWidth     = 8;
   localparam int unsigned RspDataWidth     = 8;

   localparam logic [CfgWidth-1:0] DebounceReset = 16'd3;
   localparam logic [CfgWidth-1:0] LongReset     = 16'd300;
   localparam logic [CfgWidth-1:0] RepeatReset   = 16'd80;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_DEBOUNCE = 2'd1,
      PH_PRESSED  = 2'd2,
      PH_HELD     = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_SHORT  = 2'd1,
      EV_LONG   = 2'd2,
      EV_REPEAT = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      REG_DEBOUNCE   = 2'd0,
      REG_LONG       = 2'd1,
      REG_REPEAT     = 2'd2,
      REG_REPEAT_ENA = 2'd3
   } reg_index_type;

endpackage

[design/key_press_classifier.sv]
// ----------------------------------------------------------------------------
// key_press_classifier
// Debounces an active-low key sample stream and classifies presses into
// short, long and auto-repeat events, one event code per sample.
// ----------------------------------------------------------------------------
//  channel  direction  beat contents
//  req_*    in         key_level (tdata bit 0), one sample per tick
//  rsp_*    out        key_event (tdata bits 1:0), one per sample
//  csr_*    in/out     debounce, long, repeat interval, repeat enable
//
//  one sample is accepted every cycle while req_tready is high; its event is
//  registered and offered, or held in a skid register while rsp_tready is
//  low, so req_tready drops only once both output registers are full.
//  reset is synchronous: phase to idle, counter to zero, registers to their
//  reset values, both output registers empty.
// ----------------------------------------------------------------------------
module key_press_classifier
   import kpc_pkg::*;
#(
   parameter int unsigned TIME_WIDTH = TimeWidthDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [ReqDataWidth-1:0] req_tdata,    // [0] key_level
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata,    // [1:0] key_event
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready
);

   localparam int unsigned CmpWidth = (TIME_WIDTH > CfgWidth) ? TIME_WIDTH : CfgWidth;

   logic [CfgWidth-1:0]   debounce_ff;
   logic [CfgWidth-1:0]   long_ff;
   logic [CfgWidth-1:0]   repeat_ff;
   logic                  repeat_ena_ff;

   phase_type             phase_ff, phase_in;
   logic [TIME_WIDTH-1:0] elapsed_ff, elapsed_in;
   event_type             event_in;

   logic                  rsp_valid_ff;
   event_type             rsp_event_ff;
   logic                  skid_valid_ff;
   event_type             skid_event_ff;

   logic                  csr_write;
   reg_index_type         csr_index;
   logic                  req_beat;
   logic                  rsp_beat;
   logic                  pressed;
   logic [TIME_WIDTH-1:0] elapsed_inc;
   logic [CmpWidth-1:0]   elapsed_cmp;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DebounceReset;
         long_ff       <= LongReset;
         repeat_ff     <= RepeatReset;
         repeat_ena_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            REG_DEBOUNCE:   debounce_ff   <= csr_pwdata[CfgWidth-1:0];
            REG_LONG:       long_ff       <= csr_pwdata[CfgWidth-1:0];
            REG_REPEAT:     repeat_ff     <= csr_pwdata[CfgWidth-1:0];
            REG_REPEAT_ENA: repeat_ena_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_DEBOUNCE:   csr_prdata = CsrDataWidth'(debounce_ff);
         REG_LONG:       csr_prdata = CsrDataWidth'(long_ff);
         REG_REPEAT:     csr_prdata = CsrDataWidth'(repeat_ff);
         REG_REPEAT_ENA: csr_prdata = CsrDataWidth'(repeat_ena_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // classifier
   assign req_tready = ~skid_valid_ff;
   assign req_beat   = req_tvalid & req_tready;
   assign rsp_beat   = rsp_valid_ff & rsp_tready;
   assign pressed    = ~req_tdata[0];

   assign elapsed_inc = (phase_ff != PH_IDLE && elapsed_ff != '1)
                        ? elapsed_ff + 1'b1 : elapsed_ff;
   assign elapsed_cmp = CmpWidth'(elapsed_inc);

   always_comb begin
      phase_in   = phase_ff;
      elapsed_in = elapsed_inc;
      event_in   = EV_NONE;
      case (phase_ff)
         PH_IDLE: begin
            if (pressed) begin
               phase_in   = PH_DEBOUNCE;
               elapsed_in = '0;
            end
         end
         PH_DEBOUNCE: begin
            if (!pressed) begin
               phase_in = PH_IDLE;
            end else if (elapsed_cmp > CmpWidth'(debounce_ff)) begin
               phase_in = PH_PRESSED;
            end
         end
         PH_PRESSED: begin
            if (!pressed) begin
               phase_in = PH_IDLE;
               event_in = EV_SHORT;
            end else if (elapsed_cmp > CmpWidth'(long_ff)) begin
               phase_in   = PH_HELD;
               elapsed_in = '0;
               event_in   = EV_LONG;
            end
         end
         default: begin
            if (!pressed) begin
               phase_in = PH_IDLE;
            end else if (repeat_ena_ff && elapsed_cmp > CmpWidth'(repeat_ff)) begin
               elapsed_in = '0;
               event_in   = EV_REPEAT;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         elapsed_ff <= '0;
      end else if (req_beat) begin
         phase_ff   <= phase_in;
         elapsed_ff <= elapsed_in;
      end
   end

   // output register with skid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_beat) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (req_beat) begin
         if (!rsp_valid_ff || rsp_beat) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_beat) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_beat) begin
            rsp_event_ff <= skid_event_ff;
         end
      end else if (req_beat) begin
         if (!rsp_valid_ff || rsp_beat) begin
            rsp_event_ff <= event_in;
         end else begin
            skid_event_ff <= event_in;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RspDataWidth'(rsp_event_ff);

   // checks
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full while output register empty");

   a_short_from_pressed: assert property (@(posedge clock) disable iff (reset)
      (req_beat && event_in == EV_SHORT) |-> (phase_ff == PH_PRESSED))
      else $error("short event outside pressed phase");

   a_long_restarts: assert property (@(posedge clock) disable iff (reset)
      (req_beat && event_in == EV_LONG) |=> (phase_ff == PH_HELD && elapsed_ff == '0))
      else $error("long event did not enter held phase with cleared count");

   a_repeat_enabled: assert property (@(posedge clock) disable iff (reset)
      (req_beat && event_in == EV_REPEAT) |-> (repeat_ena_ff && phase_ff == PH_HELD))
      else $error("repeat event while repeat disabled or not held");

endmodule

[tb/kpc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpc_checker
// Watches the sample, event and register channels of the key press
// classifier. Keeps its own copy of the thresholds and of the press state,
// works out the event code of every accepted sample beat and compares each
// accepted event beat with the oldest outstanding code.
// ----------------------------------------------------------------------------
module kpc_checker
   import kpc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [ReqDataWidth-1:0] req_tdata,
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [RspDataWidth-1:0] rsp_tdata,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   input  logic                    csr_pready,
   output int unsigned             fail_count,
   output int unsigned             pending_events
);

   logic [CfgWidth-1:0]         debounce_limit;
   logic [CfgWidth-1:0]         long_limit;
   logic [CfgWidth-1:0]         repeat_limit;
   logic                        repeat_on;
   phase_type                   key_phase;
   logic [TimeWidthDefault-1:0] tick_count;
   event_type                   expected_events[$];

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   function automatic event_type classify_sample(input logic key_level);
      event_type ev;
      logic      down;
      ev   = EV_NONE;
      down = !key_level;
      if (key_phase != PH_IDLE && tick_count != '1) tick_count++;
      case (key_phase)
         PH_IDLE: begin
            if (down) begin
               key_phase  = PH_DEBOUNCE;
               tick_count = '0;
            end
         end
         PH_DEBOUNCE: begin
            if (!down) key_phase = PH_IDLE;
            else if (tick_count > debounce_limit) key_phase = PH_PRESSED;
         end
         PH_PRESSED: begin
            if (!down) begin
               key_phase = PH_IDLE;
               ev        = EV_SHORT;
            end else if (tick_count > long_limit) begin
               key_phase  = PH_HELD;
               tick_count = '0;
               ev         = EV_LONG;
            end
         end
         default: begin
            if (!down) begin
               key_phase = PH_IDLE;
            end else if (repeat_on && tick_count > repeat_limit) begin
               tick_count = '0;
               ev         = EV_REPEAT;
            end
         end
      endcase
      return ev;
   endfunction

   initial begin
      fail_count     = 0;
      pending_events = 0;
   end

   always @(posedge clock) begin
      event_type want;
      if (reset) begin
         debounce_limit = DebounceReset;
         long_limit     = LongReset;
         repeat_limit   = RepeatReset;
         repeat_on      = 1'b0;
         key_phase      = PH_IDLE;
         tick_count     = '0;
         expected_events.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[3:2]))
               REG_DEBOUNCE:   debounce_limit = csr_pwdata[CfgWidth-1:0];
               REG_LONG:       long_limit     = csr_pwdata[CfgWidth-1:0];
               REG_REPEAT:     repeat_limit   = csr_pwdata[CfgWidth-1:0];
               REG_REPEAT_ENA: repeat_on      = csr_pwdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_events.push_back(classify_sample(req_tdata[0]));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_events.size() == 0) begin
               report_mismatch($sformatf("event beat %0d with none outstanding",
                                         rsp_tdata[1:0]));
            end else begin
               want = expected_events.pop_front();
               if (rsp_tdata[1:0] !== want)
                  report_mismatch($sformatf("key_event got %0d, want %0d (%s)",
                                            rsp_tdata[1:0], want, want.name()));
            end
         end
      end
      pending_events <= expected_events.size();
   end

endmodule

[tb/tb_key_press_classifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_press_classifier
// Drives key sample streams into the key press classifier: a directed part
// for bounces, thresholds, long and repeat events, then random keystrokes
// and noise under several threshold settings, with random gaps on the
// sample side and stalls on the event side.
// ----------------------------------------------------------------------------
module tb_key_press_classifier;
   import kpc_pkg::*;

   localparam int unsigned CycleLimit = 1_000_000;
   localparam int unsigned IdleNone   = 0;
   localparam int unsigned IdleSend   = 1;
   localparam int unsigned IdleRecv   = 2;
   localparam int unsigned IdleBoth   = 3;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata   = '0;   // [0] key_level
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;          // [1:0] key_event
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr   = '0;
   logic [CsrDataWidth-1:0] csr_pwdata  = '0;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   int unsigned fail_count;
   int unsigned pending_events;
   int unsigned idle_mode    = IdleNone;
   int unsigned samples_sent = 0;
   int unsigned cycle_count  = 0;

   key_press_classifier u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   kpc_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .fail_count     (fail_count),
      .pending_events (pending_events)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // event side stalls
   always @(posedge clock) begin
      case (idle_mode)
         IdleRecv: rsp_tready <= ($urandom_range(0, 99) >= 62);
         IdleBoth: rsp_tready <= ($urandom_range(0, 99) >= 6);
         default:  rsp_tready <= 1'b1;
      endcase
   end

   function automatic bit sender_gap();
      case (idle_mode)
         IdleSend: return $urandom_range(0, 99) < 62;
         IdleBoth: return $urandom_range(0, 99) < 6;
         default:  return 1'b0;
      endcase
   endfunction

   task automatic send_sample(input logic key_level);
      while (sender_gap()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(ReqDataWidth-1){1'b0}}, key_level};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      samples_sent++;
   endtask

   task automatic key_stroke(input int unsigned hold_len, input int unsigned gap_len);
      repeat (hold_len) send_sample(1'b0);
      repeat (gap_len) send_sample(1'b1);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_events != 0) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [CsrDataWidth-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // upper data bits carry junk that the block must drop
   task automatic apply_settings(input logic [15:0] deb, input logic [15:0] lng,
                                 input logic [15:0] rep, input logic ena);
      logic [CsrDataWidth-1:0] junk;
      junk = $urandom;
      wait_drained();
      csr_write(REG_DEBOUNCE, {junk[31:16], deb});
      csr_write(REG_LONG, {junk[15:0], lng});
      csr_write(REG_REPEAT, {junk[23:8], rep});
      csr_write(REG_REPEAT_ENA, {junk[31:1], ena});
   endtask

   initial begin
      logic [15:0] deb;
      logic [15:0] lng;
      logic [15:0] rep;
      logic        ena;
      int unsigned span;
      int unsigned phase_start;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset thresholds: lone bounce, exact debounce, short press
      send_sample(1'b1);
      send_sample(1'b0);
      send_sample(1'b1);
      key_stroke(4, 1);
      key_stroke(5, 1);

      // zero thresholds: long then repeats every sample, then repeat off
      apply_settings(16'd0, 16'd0, 16'd0, 1'b1);
      key_stroke(5, 1);
      apply_settings(16'd0, 16'd0, 16'd0, 1'b0);
      key_stroke(4, 1);

      for (int unsigned pass = 0; pass < 8; pass++) begin
         deb = 16'($urandom_range(0, 6));
         lng = 16'($urandom_range(0, 40));
         rep = 16'($urandom_range(0, 12));
         ena = 1'($urandom_range(0, 1));
         if (pass == 6) begin
            deb = 16'd0; lng = 16'd0; rep = 16'd0; ena = 1'b1;
         end else if (pass == 7) begin
            deb = 16'd2; lng = 16'd5; rep = 16'hFFFF; ena = 1'b1;
         end
         apply_settings(deb, lng, rep, ena);
         idle_mode   = pass % 4;
         span        = deb + lng + 3 * rep + 8;
         if (span > 120) span = 120;
         phase_start = samples_sent;
         while (samples_sent - phase_start < 120) begin
            if ($urandom_range(0, 99) < 80)
               key_stroke($urandom_range(1, span), $urandom_range(1, 4));
            else
               repeat ($urandom_range(1, 4)) send_sample(1'($urandom_range(0, 1)));
         end
         idle_mode = IdleNone;
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
